@@ design/lpcg_pkg.sv @@
// ============================================================================
// Line pixel command generator package
// Shared types and constants for the line engine, pixel queue and serialiser.
// ============================================================================
package lpcg_pkg;

    localparam int unsigned COORD_W     = 16;
    localparam int unsigned COLOR_W     = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    localparam logic [BYTE_W-1:0] COLUMN_CMD_RESET = 8'd42;
    localparam logic [BYTE_W-1:0] ROW_CMD_RESET    = 8'd43;
    localparam logic [BYTE_W-1:0] WRITE_CMD_RESET  = 8'd44;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMN_CMD = 2'd0,
        REG_ROW_CMD    = 2'd1,
        REG_WRITE_CMD  = 2'd2
    } cfg_reg_t;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Position of a byte within the nine-byte pixel sequence
    typedef enum logic [3:0] {
        SLOT_COL_CMD  = 4'd0,
        SLOT_X_HI     = 4'd1,
        SLOT_X_LO     = 4'd2,
        SLOT_ROW_CMD  = 4'd3,
        SLOT_Y_HI     = 4'd4,
        SLOT_Y_LO     = 4'd5,
        SLOT_WR_CMD   = 4'd6,
        SLOT_COLOR_HI = 4'd7,
        SLOT_COLOR_LO = 4'd8
    } byte_slot_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               done;
    } pixel_t;

endpackage

@@ design/lpcg_req_if.sv @@
// ============================================================================
// Line request channel
// Valid/ready channel carrying start and step transactions.
// ============================================================================
interface lpcg_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [15:0] pixel_color;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y, pixel_color,
        output ready
    );
endinterface

@@ design/lpcg_byte_if.sv @@
// ============================================================================
// Controller byte channel
// Valid/ready channel carrying one controller byte per transaction.
// ============================================================================
interface lpcg_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       pixel_last;
    logic       line_done;

    modport source (
        output valid, out_byte, is_data, pixel_last, line_done,
        input  ready
    );
    modport sink (
        input  valid, out_byte, is_data, pixel_last, line_done,
        output ready
    );
endinterface

@@ design/lpcg_front.sv @@
// ============================================================================
// Line engine front end
// Accepts start and step transactions and advances the Bresenham state.
// ============================================================================
module lpcg_front
    import lpcg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lpcg_req_if.sink   req,
    input  logic       push_ready,
    output logic       push_valid,
    output pixel_t     push_pixel
);

    logic [COORD_W-1:0]  cur_x_reg,  cur_x_next;
    logic [COORD_W-1:0]  cur_y_reg,  cur_y_next;
    logic [COORD_W-1:0]  target_x_reg, target_x_next;
    logic [COORD_W-1:0]  target_y_reg, target_y_next;
    logic [COORD_W:0]    delta_x_reg, delta_x_next;
    logic signed [COORD_W:0]   neg_delta_y_reg, neg_delta_y_next;
    logic                step_x_neg_reg, step_x_neg_next;
    logic                step_y_neg_reg, step_y_neg_next;
    logic signed [COORD_W+1:0] error_reg, error_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic                active_reg, active_next;

    logic                    accept;
    logic                    done;
    logic [COORD_W:0]        diff_x;
    logic [COORD_W:0]        diff_y;
    logic [COORD_W:0]        abs_x;
    logic [COORD_W:0]        abs_y;
    logic signed [COORD_W+2:0] e2;
    logic signed [COORD_W+2:0] ndy_ext;
    logic signed [COORD_W+2:0] dx_ext;
    logic                    move_x;
    logic                    move_y;

    assign req.ready = push_ready;
    assign accept    = req.valid && req.ready;
    assign done      = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);

    assign push_valid       = accept && (req.req_type == REQ_STEP) && active_reg;
    assign push_pixel.x     = cur_x_reg;
    assign push_pixel.y     = cur_y_reg;
    assign push_pixel.color = color_reg;
    assign push_pixel.done  = done;

    always_comb
    begin
        diff_x  = {1'b0, req.end_x} - {1'b0, req.start_x};
        diff_y  = {1'b0, req.end_y} - {1'b0, req.start_y};
        abs_x   = diff_x[COORD_W] ? (~diff_x + 1'b1) : diff_x;
        abs_y   = diff_y[COORD_W] ? (~diff_y + 1'b1) : diff_y;
        e2      = {error_reg, 1'b0};
        ndy_ext = (COORD_W+3)'(neg_delta_y_reg);
        dx_ext  = $signed({2'b00, delta_x_reg});
        move_x  = (e2 >= ndy_ext);
        move_y  = (e2 <= dx_ext);
    end

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        delta_x_next     = delta_x_reg;
        neg_delta_y_next = neg_delta_y_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        error_next       = error_reg;
        color_next       = color_reg;
        active_next      = active_reg;
        if (accept && (req.req_type == REQ_START))
        begin
            cur_x_next       = req.start_x;
            cur_y_next       = req.start_y;
            target_x_next    = req.end_x;
            target_y_next    = req.end_y;
            delta_x_next     = abs_x;
            neg_delta_y_next = $signed(~abs_y + 1'b1);
            step_x_neg_next  = (req.start_x >= req.end_x);
            step_y_neg_next  = (req.start_y >= req.end_y);
            error_next       = $signed({1'b0, abs_x}) - $signed({1'b0, abs_y});
            color_next       = req.pixel_color;
            active_next      = 1'b1;
        end
        else if (push_valid)
        begin
            if (done)
            begin
                active_next = 1'b0;
            end
            else
            begin
                error_next = error_reg
                           + (move_x ? (COORD_W+2)'(neg_delta_y_reg) : '0)
                           + (move_y ? $signed({1'b0, delta_x_reg}) : '0);
                if (move_x)
                begin
                    cur_x_next = step_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
                if (move_y)
                begin
                    cur_y_next = step_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            delta_x_reg     <= '0;
            neg_delta_y_reg <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            error_reg       <= '0;
            color_reg       <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            delta_x_reg     <= delta_x_next;
            neg_delta_y_reg <= neg_delta_y_next;
            step_x_neg_reg  <= step_x_neg_next;
            step_y_neg_reg  <= step_y_neg_next;
            error_reg       <= error_next;
            color_reg       <= color_next;
            active_reg      <= active_next;
        end
    end

endmodule

@@ design/lpcg_queue.sv @@
// ============================================================================
// Pixel queue
// Short FIFO of pixel descriptors between the line engine and the serialiser.
// ============================================================================
module lpcg_queue
    import lpcg_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  pixel_t push_pixel,
    output logic   pop_valid,
    input  logic   pop_ready,
    output pixel_t pop_pixel
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pixel_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_pixel  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_pixel;
        end
    end

endmodule

@@ design/lpcg_back.sv @@
// ============================================================================
// Byte serialiser
// Expands each queued pixel into nine controller bytes; holds the command
// registers.
// ============================================================================
module lpcg_back
    import lpcg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  pixel_t               pop_pixel,
    lpcg_byte_if.source          px
);

    logic [BYTE_W-1:0] column_cmd_reg;
    logic [BYTE_W-1:0] row_cmd_reg;
    logic [BYTE_W-1:0] write_cmd_reg;

    byte_slot_t        slot_reg, slot_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              data_reg;
    logic              last_reg;
    logic              done_reg;

    logic              load;
    logic              take;
    logic [BYTE_W-1:0] sel_byte;
    logic              sel_data;

    assign load      = !valid_reg || px.ready;
    assign take      = load && pop_valid;
    assign pop_ready = load && (slot_reg == SLOT_COLOR_LO);

    assign px.valid      = valid_reg;
    assign px.out_byte   = byte_reg;
    assign px.is_data    = data_reg;
    assign px.pixel_last = last_reg;
    assign px.line_done  = done_reg;

    always_comb
    begin
        sel_byte = '0;
        sel_data = 1'b1;
        unique case (slot_reg)
            SLOT_COL_CMD:
            begin
                sel_byte = column_cmd_reg;
                sel_data = 1'b0;
            end
            SLOT_X_HI:     sel_byte = pop_pixel.x[COORD_W-1 -: BYTE_W];
            SLOT_X_LO:     sel_byte = pop_pixel.x[BYTE_W-1:0];
            SLOT_ROW_CMD:
            begin
                sel_byte = row_cmd_reg;
                sel_data = 1'b0;
            end
            SLOT_Y_HI:     sel_byte = pop_pixel.y[COORD_W-1 -: BYTE_W];
            SLOT_Y_LO:     sel_byte = pop_pixel.y[BYTE_W-1:0];
            SLOT_WR_CMD:
            begin
                sel_byte = write_cmd_reg;
                sel_data = 1'b0;
            end
            SLOT_COLOR_HI: sel_byte = pop_pixel.color[COLOR_W-1 -: BYTE_W];
            SLOT_COLOR_LO: sel_byte = pop_pixel.color[BYTE_W-1:0] & BYTE_MASK;
            default:
            begin
                sel_byte = '0;
                sel_data = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
            slot_next  = (slot_reg == SLOT_COLOR_LO)
                       ? SLOT_COL_CMD : byte_slot_t'(slot_reg + 1'b1);
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_cmd_reg <= COLUMN_CMD_RESET;
            row_cmd_reg    <= ROW_CMD_RESET;
            write_cmd_reg  <= WRITE_CMD_RESET;
            slot_reg       <= SLOT_COL_CMD;
            valid_reg      <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COLUMN_CMD: column_cmd_reg <= cfg_data;
                    REG_ROW_CMD:    row_cmd_reg    <= cfg_data;
                    REG_WRITE_CMD:  write_cmd_reg  <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= sel_byte;
            data_reg <= sel_data;
            last_reg <= (slot_reg == SLOT_COLOR_LO);
            done_reg <= pop_pixel.done;
        end
    end

endmodule

@@ design/line_pixel_command_generator.sv @@
// ============================================================================
// Line pixel command generator
// Bresenham line engine producing a display controller byte stream.
// ============================================================================
// A start transaction loads both endpoints and the colour and produces no
// output; every following step transaction yields nine controller bytes for
// the current pixel (column command, x high, x low, row command, y high,
// y low, write command, colour high, colour low), each tagged with a
// data/command flag, with pixel_last on the ninth byte and line_done on all
// bytes of the final pixel. A step with no line in progress is taken and
// dropped. The line engine takes one transaction per cycle while the pixel
// queue has room; the serialiser emits one byte per cycle while px.ready is
// high, so the sustained step rate is set by the single byte output port.
// A step's pixel is written into the queue, its first byte then into the
// output register. Command bytes come from three registers that the user
// must write through the cfg port only while the block is idle (not enforced).
// ============================================================================
module line_pixel_command_generator
    import lpcg_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    lpcg_req_if.sink             req,
    lpcg_byte_if.source          px
);

    // Pixel descriptors between the line engine and the serialiser
    logic   push_valid;
    logic   push_ready;
    pixel_t push_pixel;
    logic   pop_valid;
    logic   pop_ready;
    pixel_t pop_pixel;

    // Front end: decode start/step, advance the error terms
    lpcg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_pixel (push_pixel)
    );

    // Decouple the engine from output back-pressure
    lpcg_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_pixel (push_pixel),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_pixel  (pop_pixel)
    );

    // Back end: serialise each pixel into nine byte transactions
    lpcg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_pixel (pop_pixel),
        .px        (px)
    );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Line pixel command generator testbench
// Drives start and step transactions with random gaps and stalls, predicts
// every nine-byte pixel sequence with a Bresenham tracker and checks each
// controller byte in order.
// ============================================================================
module tb_top;
    import lpcg_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 500000;
    localparam int unsigned SETTLE_CYCLES    = 16;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned MAX_GAP          = 14;
    localparam int unsigned PHASE_ITEMS      = 100;

    // Index past the end of the register list: writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] pixel_color;
    } line_req_t;

    // One row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        line_req_t          req;
        logic               typed;
        logic               typed_px;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [COLOR_W-1:0] tcolor;
        logic               tdone;
    } directed_row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              is_data;
        logic              last;
        logic              done;
    } ctl_byte_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    lpcg_req_if  req_ch ();
    lpcg_byte_if pix_ch ();

    line_pixel_command_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .px        (pix_ch)
    );

    // Register copies
    logic [BYTE_W-1:0] reg_col_cmd;
    logic [BYTE_W-1:0] reg_row_cmd;
    logic [BYTE_W-1:0] reg_wr_cmd;

    // Line tracker state
    logic [COORD_W-1:0] ln_x;
    logic [COORD_W-1:0] ln_y;
    logic [COORD_W-1:0] ln_tx;
    logic [COORD_W-1:0] ln_ty;
    logic signed [16:0] ln_dx;
    logic signed [16:0] ln_ndy;
    logic               ln_xneg;
    logic               ln_yneg;
    logic signed [17:0] ln_err;
    logic [COLOR_W-1:0] ln_color;
    logic               ln_active;

    ctl_byte_t pending_bytes[$];

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned pixels_checked;
    int unsigned lines_started;
    int unsigned settings_applied;
    int unsigned long_holds;
    bit          sender_burst;
    bit          sink_burst;
    bit          hold_request;
    bit          hold_request_armed;

    directed_row_t directed_rows[23];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: stop a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes outstanding", $realtime,
                     pending_bytes.size());
            $display("line_pixel_command_generator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Track one accepted transaction; return the pixel it emits, if any
    task automatic bresenham_predict(input line_req_t it, output bit has_px,
                                     output pixel_t pix);
        int x1;
        int y1;
        int x2;
        int y2;
        int ax;
        int ay;
        logic signed [18:0] twice_err;
        has_px = 1'b0;
        pix    = '0;
        if (it.req_type == REQ_START)
        begin
            // Load a fresh line; any line in progress is dropped
            x1 = int'(it.start_x);
            y1 = int'(it.start_y);
            x2 = int'(it.end_x);
            y2 = int'(it.end_y);
            ax = (x2 > x1) ? x2 - x1 : x1 - x2;
            ay = (y2 > y1) ? y2 - y1 : y1 - y2;
            ln_x      = it.start_x;
            ln_y      = it.start_y;
            ln_tx     = it.end_x;
            ln_ty     = it.end_y;
            ln_dx     = 17'(ax);
            ln_ndy    = 17'(-ay);
            ln_xneg   = !(x1 < x2);
            ln_yneg   = !(y1 < y2);
            ln_err    = ln_dx + ln_ndy;
            ln_color  = it.pixel_color;
            ln_active = 1'b1;
            lines_started++;
        end
        else if (ln_active)
        begin
            has_px     = 1'b1;
            pix.x      = ln_x;
            pix.y      = ln_y;
            pix.color  = ln_color;
            pix.done   = (ln_x == ln_tx) && (ln_y == ln_ty);
            if (pix.done)
                ln_active = 1'b0;
            else
            begin
                twice_err = {ln_err, 1'b0};
                if (twice_err >= ln_ndy)
                begin
                    ln_err = ln_err + ln_ndy;
                    ln_x   = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
                end
                if (twice_err <= ln_dx)
                begin
                    ln_err = ln_err + ln_dx;
                    ln_y   = ln_yneg ? ln_y - 1'b1 : ln_y + 1'b1;
                end
            end
        end
    endtask

    // Expand one pixel into its nine controller bytes
    function automatic void queue_pixel_bytes(pixel_t pix);
        pending_bytes.push_back('{reg_col_cmd,       1'b0, 1'b0, pix.done});
        pending_bytes.push_back('{pix.x[15:8],       1'b1, 1'b0, pix.done});
        pending_bytes.push_back('{pix.x[7:0],        1'b1, 1'b0, pix.done});
        pending_bytes.push_back('{reg_row_cmd,       1'b0, 1'b0, pix.done});
        pending_bytes.push_back('{pix.y[15:8],       1'b1, 1'b0, pix.done});
        pending_bytes.push_back('{pix.y[7:0],        1'b1, 1'b0, pix.done});
        pending_bytes.push_back('{reg_wr_cmd,        1'b0, 1'b0, pix.done});
        pending_bytes.push_back('{pix.color[15:8],   1'b1, 1'b0, pix.done});
        pending_bytes.push_back('{pix.color[7:0],    1'b1, 1'b1, pix.done});
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one transaction after a random gap and track it once accepted
    task automatic offer(input line_req_t it, output bit has_px, output pixel_t pix);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= it.req_type;
        req_ch.start_x     <= it.start_x;
        req_ch.start_y     <= it.start_y;
        req_ch.end_x       <= it.end_x;
        req_ch.end_y       <= it.end_y;
        req_ch.pixel_color <= it.pixel_color;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        bresenham_predict(it, has_px, pix);
    endtask

    // Drop valid, wait for every expected byte, then let the pipeline settle
    task automatic wait_for_idle();
        req_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three command registers plus the unused index
    task automatic program_registers(input logic [BYTE_W-1:0] col,
                                     input logic [BYTE_W-1:0] row,
                                     input logic [BYTE_W-1:0] wr);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [BYTE_W-1:0]    val[4];
        idx = '{REG_UNUSED, REG_COLUMN_CMD, REG_ROW_CMD, REG_WRITE_CMD};
        val = '{8'($urandom_range(0, 255)), col, row, wr};
        for (int k = 0; k < 4; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            case (idx[k])
                REG_COLUMN_CMD: reg_col_cmd = val[k];
                REG_ROW_CMD:    reg_row_cmd = val[k];
                REG_WRITE_CMD:  reg_wr_cmd  = val[k];
                default:        ;
            endcase
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [COORD_W-1:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 7));
            1:       return 16'hFFFF - 16'($urandom_range(0, 7));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Endpoint a short distance from base, held inside the coordinate range
    function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] base);
        int c;
        c = int'(base) + int'($urandom_range(0, 18)) - 9;
        if (c < 0)
            c = 0;
        if (c > 65535)
            c = 65535;
        return 16'(c);
    endfunction

    function automatic line_req_t random_step();
        return '{REQ_STEP, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535))};
    endfunction

    // Mostly complete short lines; some long lines abandoned part way,
    // truncated lines, and stray steps
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        int unsigned cap;
        int unsigned steps;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        line_req_t it;
        bit has_px;
        pixel_t pix;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                it = random_step();
                sent++;
                offer(it, has_px, pix);
                if (has_px)
                    queue_pixel_bytes(pix);
            end
            else
            begin
                if (kind <= 2)
                begin
                    it = '{REQ_START, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
                    cap = $urandom_range(1, 4);
                end
                else
                begin
                    bx = pick_base();
                    by = pick_base();
                    it = '{REQ_START, bx, by, near_coord(bx), near_coord(by),
                           16'($urandom_range(0, 65535))};
                    cap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 64;
                end
                offer(it, has_px, pix);
                sent++;
                if (hold_request_armed)
                begin
                    hold_request       = 1'b1;
                    hold_request_armed = 1'b0;
                end
                steps = 0;
                while (ln_active && steps < cap)
                begin
                    offer(random_step(), has_px, pix);
                    if (has_px)
                        queue_pixel_bytes(pix);
                    steps++;
                    sent++;
                end
                // Now and then a step after the line has ended
                if (!ln_active && $urandom_range(0, 3) == 0)
                begin
                    offer(random_step(), has_px, pix);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------
    initial
    begin : byte_sink
        int unsigned gap;
        ctl_byte_t got;
        ctl_byte_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_request)
            begin
                // Hold off long enough for the pixel queue to fill
                gap          = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
                long_holds++;
            end
            if (gap > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pix_ch.ready <= 1'b1;
            @(posedge clk);
            while (!pix_ch.valid)
                @(posedge clk);
            got = '{pix_ch.out_byte, pix_ch.is_data, pix_ch.pixel_last, pix_ch.line_done};
            // Fields shown as byte, then data/last/done flags
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual %02h %b%b%b",
                         $realtime, got.value, got.is_data, got.last, got.done);
                mismatches++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (got !== want)
                begin
                    $display("%0t: byte mismatch: expected %02h %b%b%b, actual %02h %b%b%b",
                             $realtime, want.value, want.is_data, want.last, want.done,
                             got.value, got.is_data, got.last, got.done);
                    mismatches++;
                end
                bytes_checked++;
                if (want.last)
                    pixels_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        directed_row_t row;
        bit has_px;
        pixel_t pix;

        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_COLUMN_CMD;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_START;
        req_ch.start_x     = '0;
        req_ch.start_y     = '0;
        req_ch.end_x       = '0;
        req_ch.end_y       = '0;
        req_ch.pixel_color = '0;
        pix_ch.ready       = 1'b0;
        cycle_count        = 0;
        mismatches         = 0;
        bytes_checked      = 0;
        pixels_checked     = 0;
        lines_started      = 0;
        settings_applied   = 0;
        long_holds         = 0;
        sender_burst       = 1'b0;
        sink_burst         = 1'b0;
        hold_request       = 1'b0;
        hold_request_armed = 1'b0;

        reg_col_cmd = COLUMN_CMD_RESET;
        reg_row_cmd = ROW_CMD_RESET;
        reg_wr_cmd  = WRITE_CMD_RESET;
        ln_x = '0; ln_y = '0; ln_tx = '0; ln_ty = '0;
        ln_dx = '0; ln_ndy = '0; ln_xneg = 1'b0; ln_yneg = 1'b0;
        ln_err = '0; ln_color = '0; ln_active = 1'b0;

        // Directed table: request, typed flag, typed pixel flag, x, y, colour, done
        directed_rows = '{
            // step straight after reset: nothing to emit
            '{'{REQ_STEP,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
              1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            // single point at the origin, full white
            '{'{REQ_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF},
              1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b1, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 1'b1},
            // line finished: step is dropped
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            // single point at the far corner, black
            '{'{REQ_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
              1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1},
            // shallow line, both steps positive
            '{'{REQ_START, 16'h0000, 16'h0000, 16'h0003, 16'h0001, 16'hA5A5},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            // diagonal from the right edge, x falling
            '{'{REQ_START, 16'hFFFF, 16'h0000, 16'hFFFD, 16'h0002, 16'h5A5A},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            // new start while a line is in progress: steep, both falling
            '{'{REQ_START, 16'h8001, 16'h8000, 16'h8000, 16'h7FFE, 16'h1234},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            // vertical line, y falling
            '{'{REQ_START, 16'h0007, 16'h0003, 16'h0007, 16'h0000, 16'h0F0F},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
            '{'{REQ_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
              1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset register values
        for (int r = 0; r < $size(directed_rows); r++)
        begin
            row = directed_rows[r];
            offer(row.req, has_px, pix);
            if (row.typed)
            begin
                if (row.typed_px)
                    queue_pixel_bytes('{x: row.tx, y: row.ty, color: row.tcolor,
                                        done: row.tdone});
            end
            else if (has_px)
                queue_pixel_bytes(pix);
        end
        wait_for_idle();

        // All-zero commands; random gaps on both sides
        program_registers(8'h00, 8'h00, 8'h00);
        run_random_phase(PHASE_ITEMS);
        wait_for_idle();

        // All-ones commands; sender flat out while the receiver holds off
        program_registers(8'hFF, 8'hFF, 8'hFF);
        sender_burst       = 1'b1;
        hold_request_armed = 1'b1;
        run_random_phase(PHASE_ITEMS);
        wait_for_idle();

        // Random commands; no idling on either side
        program_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
        sink_burst = 1'b1;
        run_random_phase(PHASE_ITEMS);
        wait_for_idle();

        // Random commands again with random gaps
        sender_burst = 1'b0;
        sink_burst   = 1'b0;
        program_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
        run_random_phase(PHASE_ITEMS);
        wait_for_idle();

        $display("Covered %0d lines, %0d pixels, %0d bytes over %0d register settings",
                 lines_started, pixels_checked, bytes_checked, settings_applied + 1);
        $display("Long receiver hold-offs: %0d; mismatches: %0d", long_holds, mismatches);
        if (mismatches == 0)
            $display("line_pixel_command_generator verification clean");
        else
            $display("line_pixel_command_generator verification failed");
        $finish;
    end

endmodule
